// ===== hw/rtl/mwc_pkg.sv =====
// Package for the multiply-with-carry generator: constants, types, coefficient table.
`default_nettype none
package mwc_pkg;

  localparam int WORD_W       = 32;
  localparam int ACC_W        = 2 * WORD_W;
  localparam int HIST_DEPTH   = 4;
  localparam int HIST_IDX_W   = $clog2(HIST_DEPTH);
  localparam int STEP_W       = $clog2(HIST_DEPTH + 1);
  localparam int WARMUP_DRAWS = 19;
  localparam int WARM_W       = $clog2(WARMUP_DRAWS + 2);

  localparam logic [WORD_W-1:0] MULT_NEW  = 32'd5115;
  localparam logic [WORD_W-1:0] MULT_1    = 32'd1776;
  localparam logic [WORD_W-1:0] MULT_2    = 32'd1492;
  localparam logic [WORD_W-1:0] MULT_OLD  = 32'd2111111111;
  localparam logic [WORD_W-1:0] SEED_MULT = 32'd29943829;

  localparam logic [WORD_W-1:0] HIST0_RST = 32'h95d3474b;
  localparam logic [WORD_W-1:0] HIST1_RST = 32'h035cf1f7;
  localparam logic [WORD_W-1:0] HIST2_RST = 32'hfd43995f;
  localparam logic [WORD_W-1:0] HIST3_RST = 32'h5dfc55fb;
  localparam logic [WORD_W-1:0] CARRY_RST = 32'h334a9229;

  // Operation codes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_MAC,
    ST_DRAW_COMMIT,
    ST_SEED_MUL,
    ST_SEED_WR
  } mwc_state_t;

  typedef struct packed {
    logic                  mul_en;
    logic                  mul_seed;
    logic [HIST_IDX_W-1:0] mul_idx;
    logic                  acc_load;
    logic                  acc_add;
    logic                  draw_commit;
    logic                  draw_emit;
    logic                  seed_step;
    logic [STEP_W-1:0]     seed_idx;
  } mwc_ctrl_t;

  function automatic logic [WORD_W-1:0] draw_coef(input logic [HIST_IDX_W-1:0] idx);
    logic [WORD_W-1:0] c;
    case (idx)
      2'd0:    c = MULT_NEW;
      2'd1:    c = MULT_1;
      2'd2:    c = MULT_2;
      2'd3:    c = MULT_OLD;
      default: c = MULT_NEW;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mwc_if.sv =====
// Valid/ready channel interfaces for draw/reseed requests and generated words.
`default_nettype none
interface mwc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [mwc_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface mwc_out_if;
  logic                      valid;
  logic                      ready;
  logic [mwc_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mwc_mul.sv =====
// Shared 32x32 multiplier with registered 64-bit product.
`default_nettype none
module mwc_mul (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [mwc_pkg::WORD_W-1:0]  a,
  input  wire logic [mwc_pkg::WORD_W-1:0]  b,
  output logic      [mwc_pkg::ACC_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mwc_pkg::ACC_W'(a) * mwc_pkg::ACC_W'(b);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mwc_seq.sv =====
// Sequencer for draw accumulation, seed chain and warm-up draws.
`default_nettype none
module mwc_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               start_op,
  input  wire logic               out_stall,
  output logic                    in_ready,
  output mwc_pkg::mwc_ctrl_t      ctrl
);

  mwc_pkg::mwc_state_t               state_r, state_nxt;
  logic [mwc_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [mwc_pkg::STEP_W-1:0]        sidx_r, sidx_nxt;
  logic [mwc_pkg::WARM_W-1:0]        warm_r, warm_nxt;
  logic                              user_r, user_nxt;
  logic                              commit_ok;

  assign commit_ok = !(user_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sidx_nxt  = sidx_r;
    warm_nxt  = warm_r;
    user_nxt  = user_r;
    case (state_r)
      mwc_pkg::ST_IDLE: begin
        if (start) begin
          step_nxt = '0;
          sidx_nxt = '0;
          if (start_op == mwc_pkg::OP_RESEED) begin
            state_nxt = mwc_pkg::ST_SEED_MUL;
          end else begin
            state_nxt = mwc_pkg::ST_DRAW_MAC;
            user_nxt  = 1'b1;
          end
        end
      end
      mwc_pkg::ST_DRAW_MAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == mwc_pkg::STEP_W'(mwc_pkg::HIST_DEPTH)) begin
          state_nxt = mwc_pkg::ST_DRAW_COMMIT;
        end
      end
      mwc_pkg::ST_DRAW_COMMIT: begin
        if (commit_ok) begin
          step_nxt = '0;
          if (user_r) begin
            state_nxt = mwc_pkg::ST_IDLE;
          end else begin
            warm_nxt = warm_r - 1'b1;
            if (warm_r == mwc_pkg::WARM_W'(1)) begin
              state_nxt = mwc_pkg::ST_IDLE;
            end else begin
              state_nxt = mwc_pkg::ST_DRAW_MAC;
            end
          end
        end
      end
      mwc_pkg::ST_SEED_MUL: begin
        state_nxt = mwc_pkg::ST_SEED_WR;
      end
      mwc_pkg::ST_SEED_WR: begin
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == mwc_pkg::STEP_W'(mwc_pkg::HIST_DEPTH)) begin
          // seed chain done; carry written, start warm-up
          step_nxt = '0;
          user_nxt = 1'b0;
          warm_nxt = mwc_pkg::WARM_W'(mwc_pkg::WARMUP_DRAWS);
          if (mwc_pkg::WARMUP_DRAWS == 0) begin
            state_nxt = mwc_pkg::ST_IDLE;
          end else begin
            state_nxt = mwc_pkg::ST_DRAW_MAC;
          end
        end else begin
          state_nxt = mwc_pkg::ST_SEED_MUL;
        end
      end
      default: state_nxt = mwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    ctrl             = '0;
    ctrl.mul_idx     = step_r[mwc_pkg::HIST_IDX_W-1:0];
    ctrl.seed_idx    = sidx_r;
    case (state_r)
      mwc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      mwc_pkg::ST_DRAW_MAC: begin
        ctrl.mul_en   = (step_r != mwc_pkg::STEP_W'(mwc_pkg::HIST_DEPTH));
        ctrl.acc_load = (step_r == '0);
        ctrl.acc_add  = (step_r != '0);
      end
      mwc_pkg::ST_DRAW_COMMIT: begin
        ctrl.draw_commit = commit_ok;
        ctrl.draw_emit   = commit_ok && user_r;
      end
      mwc_pkg::ST_SEED_MUL: begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_seed = 1'b1;
      end
      mwc_pkg::ST_SEED_WR: begin
        ctrl.seed_step = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwc_pkg::ST_IDLE;
      step_r  <= '0;
      sidx_r  <= '0;
      warm_r  <= '0;
      user_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sidx_r  <= sidx_nxt;
      warm_r  <= warm_nxt;
      user_r  <= user_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multiply_with_carry_rng.sv =====
// Draw: accept, multiply-accumulate of the four history words onto the carry on
// the shared multiplier, then commit; the commit loads the word into the output
// register, and no new request is taken before it (it waits while a word is held).
// Reseed: seed chain for the four history words and carry, plus 19 warm-up draws.
// Synchronous active-low reset loads the fixed history and carry and empties output.
// The single 32x32 multiplier serves both the draw and the seed-chain steps.
`default_nettype none
module multiply_with_carry_rng (
  input  wire logic    clk,
  input  wire logic    rst_n,
  mwc_in_if.sink       in_ch,
  mwc_out_if.source    out_ch
);

  mwc_pkg::mwc_ctrl_t              ctrl;
  logic                            in_ready;
  logic                            in_xfer;
  logic                            out_valid_r;
  logic [mwc_pkg::WORD_W-1:0]      out_word_r;
  logic [mwc_pkg::WORD_W-1:0]      hist_r [mwc_pkg::HIST_DEPTH];
  logic [mwc_pkg::WORD_W-1:0]      carry_r;
  logic [mwc_pkg::WORD_W-1:0]      seed_r;
  logic [mwc_pkg::ACC_W-1:0]       acc_r;
  logic [mwc_pkg::ACC_W-1:0]       prod_r;
  logic [mwc_pkg::WORD_W-1:0]      mul_a;
  logic [mwc_pkg::WORD_W-1:0]      mul_b;
  logic [mwc_pkg::WORD_W-1:0]      seed_next;

  assign in_ch.ready  = in_ready;
  assign in_xfer      = in_ch.valid && in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.random_word = out_word_r;

  mwc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .start_op  (in_ch.operation),
    .out_stall (out_valid_r && !out_ch.ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  assign mul_a = ctrl.mul_seed ? seed_r : hist_r[ctrl.mul_idx];
  assign mul_b = ctrl.mul_seed ? mwc_pkg::SEED_MULT : mwc_pkg::draw_coef(ctrl.mul_idx);

  mwc_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign seed_next = prod_r[mwc_pkg::WORD_W-1:0] - 1'b1;

  // Accumulator and seed chain register
  always_ff @(posedge clk) begin
    if (ctrl.acc_load) begin
      acc_r <= mwc_pkg::ACC_W'(carry_r);
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (in_xfer) begin
      seed_r <= in_ch.seed_value;
    end else if (ctrl.seed_step) begin
      seed_r <= seed_next;
    end
  end

  // Generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0] <= mwc_pkg::HIST0_RST;
      hist_r[1] <= mwc_pkg::HIST1_RST;
      hist_r[2] <= mwc_pkg::HIST2_RST;
      hist_r[3] <= mwc_pkg::HIST3_RST;
      carry_r   <= mwc_pkg::CARRY_RST;
    end else if (ctrl.draw_commit) begin
      for (int i = mwc_pkg::HIST_DEPTH - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= acc_r[mwc_pkg::WORD_W-1:0];
      carry_r   <= acc_r[mwc_pkg::ACC_W-1:mwc_pkg::WORD_W];
    end else if (ctrl.seed_step) begin
      if (ctrl.seed_idx == mwc_pkg::STEP_W'(mwc_pkg::HIST_DEPTH)) begin
        carry_r <= seed_next;
      end else begin
        hist_r[ctrl.seed_idx[mwc_pkg::HIST_IDX_W-1:0]] <= seed_next;
      end
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.draw_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.draw_emit) begin
      out_word_r <= acc_r[mwc_pkg::WORD_W-1:0];
    end
  end

endmodule
`default_nettype wire
